FILE: src/dtt_pkg.sv
package dtt_pkg;

    // Table size and field widths
    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int ID_W        = 4;
    localparam int DELAY_W     = 31;
    localparam int TIME_W      = 32;
    localparam int CMP_W       = (SLOT_W > ID_W) ? SLOT_W : ID_W;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_ADJUST   = 2'd1,
        ACT_QUERY    = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    typedef enum logic {
        KIND_EXPIRE = 1'b0,
        KIND_REMAIN = 1'b1
    } t_kind;

    // Request token walking down the cell row
    typedef struct packed {
        logic               valid;
        t_action            action;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  rem;
    } t_tok;

    // Expiry report raised by one cell
    typedef struct packed {
        logic              hit;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] value;
    } t_rep;

endpackage

FILE: src/dtt_cell.sv
module dtt_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [dtt_pkg::SLOT_W-1:0] i_slot,
    input  dtt_pkg::t_tok              i_tok,
    output dtt_pkg::t_tok              o_tok,
    output dtt_pkg::t_rep              o_rep,
    output logic                       o_busy
);
    import dtt_pkg::*;

    t_tok              r_tok;
    logic              r_active;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_deadline;

    logic              n_active;
    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] n_deadline;

    logic              match;
    logic              delay_nz;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] delay_ext;

    always_comb begin
        match     = (CMP_W'(r_tok.id) == CMP_W'(i_slot));
        delay_nz  = (r_tok.delay != '0);
        delay_ext = {1'b0, r_tok.delay};
        diff      = r_deadline - r_tok.now;

        n_active   = r_active;
        n_start    = r_start;
        n_deadline = r_deadline;
        o_tok      = r_tok;
        o_rep      = '0;

        case (r_tok.action)
            ACT_REGISTER: begin
                if (r_tok.valid && match && delay_nz) begin
                    n_active   = 1'b1;
                    n_start    = r_tok.now;
                    n_deadline = r_tok.now + delay_ext;
                end
            end
            ACT_ADJUST: begin
                if (r_tok.valid && match && delay_nz && r_active) begin
                    n_deadline = r_deadline + delay_ext;
                end
            end
            ACT_QUERY: begin
                // negative remainder clamps to zero (token already carries 0)
                if (r_tok.valid && match && r_active && !diff[TIME_W-1]) begin
                    o_tok.rem = diff;
                end
            end
            ACT_TICK: begin
                // wrap-safe: due when deadline - now is zero or negative
                if (r_tok.valid && r_active && ((diff == '0) || diff[TIME_W-1])) begin
                    n_active    = 1'b0;
                    o_rep.hit   = 1'b1;
                    o_rep.id    = ID_W'(i_slot);
                    o_rep.value = r_tok.now - r_start;
                end
            end
            default: begin
            end
        endcase

        o_busy = r_tok.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_active    <= 1'b0;
        end else if (i_adv) begin
            r_tok      <= i_tok;
            r_active   <= n_active;
            r_start    <= n_start;
            r_deadline <= n_deadline;
        end
    end

endmodule

FILE: src/deadline_timer_table.sv
// A request walks the cell row one slot per cycle unless the output stalls,
//   then enters the tail stage; a query answer or the final expiry report is
//   registered by every cell, the tail stage and then the output register.
// The row holds one request; a new one is accepted only once the row is empty.
// Reset (i_rst_n low, synchronous): all slots disarmed, last tick time zero,
//   row and output register empty. Timer times are undefined until armed.
module deadline_timer_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [dtt_pkg::ID_W-1:0]    i_timer_id,
    input  logic [dtt_pkg::DELAY_W-1:0] i_delay_ms,
    input  logic [dtt_pkg::TIME_W-1:0]  i_now_ms,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_report_kind,
    output logic [dtt_pkg::ID_W-1:0]    o_report_id,
    output logic [dtt_pkg::TIME_W-1:0]  o_report_value,
    output logic                        o_last
);
    import dtt_pkg::*;

    // Token links: link[i] feeds cell i, link[TIMER_SLOTS] feeds the tail stage
    t_tok tok_link [0:TIMER_SLOTS];
    t_rep cell_rep [0:TIMER_SLOTS-1];
    logic [TIMER_SLOTS-1:0] cell_busy;

    // Tail stage: finishes query answers and flushes the held expiry report
    t_tok r_tail;

    // One expiry report held back until we know whether it is the final one
    logic              r_pend_valid;
    logic [ID_W-1:0]   r_pend_id;
    logic [TIME_W-1:0] r_pend_value;
    logic              n_pend_valid;
    logic [ID_W-1:0]   n_pend_id;
    logic [TIME_W-1:0] n_pend_value;

    logic [TIME_W-1:0] r_last_tick;

    // Output register
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [ID_W-1:0]   r_out_id;
    logic [TIME_W-1:0] r_out_value;
    logic              r_out_last;

    logic              push;
    t_kind             push_kind;
    logic [ID_W-1:0]   push_id;
    logic [TIME_W-1:0] push_value;
    logic              push_last;

    t_rep rep;
    logic adv;
    logic busy;
    logic accept;
    logic is_tick;
    logic tick_repeat;

    // Whole row steps together whenever the output register can take a report
    assign adv    = !r_out_valid || i_out_ready;
    assign busy   = (|cell_busy) || r_tail.valid;
    assign o_in_ready = !busy && adv;
    assign accept = i_in_valid && o_in_ready;

    assign is_tick     = (t_action'(i_action) == ACT_TICK);
    assign tick_repeat = is_tick && (i_now_ms == r_last_tick);

    always_comb begin
        tok_link[0].valid  = accept && !tick_repeat;
        tok_link[0].action = t_action'(i_action);
        tok_link[0].id     = i_timer_id;
        tok_link[0].delay  = i_delay_ms;
        tok_link[0].now    = i_now_ms;
        tok_link[0].rem    = '0;
    end

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        dtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_slot  (SLOT_W'(g)),
            .i_tok   (tok_link[g]),
            .o_tok   (tok_link[g+1]),
            .o_rep   (cell_rep[g]),
            .o_busy  (cell_busy[g])
        );
    end

    // At most one cell holds the token, so the reports merge by OR
    always_comb begin
        rep = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            rep = t_rep'(rep | cell_rep[i]);
        end
    end

    // Each step pushes at most one report into the output register
    always_comb begin
        push         = 1'b0;
        push_kind    = KIND_EXPIRE;
        push_id      = r_pend_id;
        push_value   = r_pend_value;
        push_last    = 1'b0;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_value = r_pend_value;

        if (rep.hit) begin
            // new expiry: release the held one as a non-final report
            push         = r_pend_valid;
            n_pend_valid = 1'b1;
            n_pend_id    = rep.id;
            n_pend_value = rep.value;
        end else if (r_tail.valid) begin
            if (r_tail.action == ACT_QUERY) begin
                push       = 1'b1;
                push_kind  = KIND_REMAIN;
                push_id    = r_tail.id;
                push_value = r_tail.rem;
                push_last  = 1'b1;
            end else if (r_tail.action == ACT_TICK) begin
                push         = r_pend_valid;
                push_last    = 1'b1;
                n_pend_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail.valid <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_tick  <= '0;
        end else begin
            if (accept && is_tick) begin
                r_last_tick <= i_now_ms;
            end
            if (adv) begin
                r_tail       <= tok_link[TIMER_SLOTS];
                r_pend_valid <= n_pend_valid;
                r_pend_id    <= n_pend_id;
                r_pend_value <= n_pend_value;
                r_out_valid  <= push;
                if (push) begin
                    r_out_kind  <= push_kind;
                    r_out_id    <= push_id;
                    r_out_value <= push_value;
                    r_out_last  <= push_last;
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_report_kind  = r_out_kind;
    assign o_report_id    = r_out_id;
    assign o_report_value = r_out_value;
    assign o_last         = r_out_last;

endmodule
